// ----- rtl/assert_macros.svh -----
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled during reset
`define ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication, disabled during reset
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ----- rtl/tlht_pkg.sv -----
// shared types and constants of the two-level hash table
`timescale 1ns / 1ps
package tlht_pkg;

  localparam int DEF_MAX_BUCKETS = 8;
  localparam int DEF_MAX_SLOTS   = 16;
  localparam int KEY_W  = 31;
  localparam int VAL_W  = 32;
  localparam int BC_W   = 4;
  localparam int SC_W   = 5;
  localparam int CFG_W  = 5;
  localparam int DIV_W  = 5;
  localparam int WORD_W = 1 + KEY_W + VAL_W;
  localparam int STEP_W = 4;
  // two remainder bits per step: 16 steps over a 32-bit dividend, 2 over 4 bits
  localparam logic [STEP_W-1:0] KEY_STEPS_LAST   = 4'd15;
  localparam logic [STEP_W-1:0] START_STEPS_LAST = 4'd1;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_FIND   = 2'd1,
    ACT_DELETE = 2'd2,
    ACT_NONE   = 2'd3
  } action_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NO_ROOM   = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_UNUSED    = 2'd3
  } status_t;

  localparam logic CFG_BUCKET_COUNT = 1'b0;
  localparam logic CFG_SLOTS_IN_USE = 1'b1;

  // commands from controller to datapath
  typedef struct packed {
    logic    load_item;
    logic    div_step;
    logic    div_sel_slots;
    logic    load_start;
    logic    probe_init;
    logic    probe_next;
    logic    ram_rd;
    logic    wr_insert;
    logic    wr_delete;
    logic    clear_step;
    logic    res_load;
    status_t res_status;
    logic    res_value;
  } cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic slot_empty;
    logic slot_match;
    logic last_slot;
    logic clear_last;
    logic out_full;
  } stat_t;

endpackage

// ----- rtl/tlht_ram.sv -----
// generic single-port ram with registered read
`timescale 1ns / 1ps
module tlht_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 128
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic                                   re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

// ----- rtl/tlht_datapath.sv -----
// datapath: config registers, remainder unit, probe address, table ram, result register
`timescale 1ns / 1ps
module tlht_datapath import tlht_pkg::*; #(
  parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
  parameter int MAX_SLOTS   = DEF_MAX_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data,
  input  logic [KEY_W-1:0]  key,
  input  logic [VAL_W-1:0]  value,
  input  logic              out_stall,
  output logic              out_valid,
  output logic [1:0]        status,
  output logic [VAL_W-1:0]  found_value,
  input  cmd_t              cmd,
  output stat_t             stat
);

  localparam int DEPTH = MAX_BUCKETS * MAX_SLOTS;
  localparam int AW    = DEPTH > 1 ? $clog2(DEPTH) : 1;
  localparam int SW    = MAX_SLOTS > 1 ? $clog2(MAX_SLOTS) : 1;

  logic [BC_W-1:0]   bucket_count;
  logic [SC_W-1:0]   slots_in_use;
  logic [BC_W-1:0]   nb_eff;
  logic [SC_W-1:0]   ns_eff;
  logic [KEY_W-1:0]  key_reg;
  logic [VAL_W-1:0]  val_reg;
  logic [31:0]       dvd;
  logic [DIV_W-1:0]  rem;
  logic [DIV_W-1:0]  divisor;
  logic [DIV_W+1:0]  t0, t1, t2, d2, d1;
  logic [BC_W-1:0]   bucket;
  logic [SW-1:0]     slot;
  logic [SC_W-1:0]   cnt;
  logic [AW-1:0]     clr_addr;
  logic [AW-1:0]     probe_addr;
  logic              ram_we;
  logic [AW-1:0]     ram_addr;
  logic [WORD_W-1:0] ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      bucket_count <= 4'd8;
      slots_in_use <= 5'd16;
    end else if (cfg_we) begin
      if (cfg_index == CFG_BUCKET_COUNT) begin
        bucket_count <= cfg_data[BC_W-1:0];
      end else begin
        slots_in_use <= cfg_data[SC_W-1:0];
      end
    end
  end

  // clamp the counts into their legal range
  always_comb begin
    if (bucket_count == '0) begin
      nb_eff = BC_W'(1);
    end else if (32'(bucket_count) > MAX_BUCKETS) begin
      nb_eff = BC_W'(MAX_BUCKETS);
    end else begin
      nb_eff = bucket_count;
    end
    if (slots_in_use == '0) begin
      ns_eff = SC_W'(1);
    end else if (32'(slots_in_use) > MAX_SLOTS) begin
      ns_eff = SC_W'(MAX_SLOTS);
    end else begin
      ns_eff = slots_in_use;
    end
  end

  // radix-4 remainder step: two conditional subtracts
  assign divisor = cmd.div_sel_slots ? ns_eff : {1'b0, nb_eff};
  assign d1 = {2'b00, divisor};
  assign d2 = {1'b0, divisor, 1'b0};
  assign t0 = {rem, dvd[31:30]};
  assign t1 = (t0 >= d2) ? t0 - d2 : t0;
  assign t2 = (t1 >= d1) ? t1 - d1 : t1;

  // item registers, remainder unit and probe position
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      key_reg <= key;
      val_reg <= value;
      dvd     <= {1'b0, key};
      rem     <= '0;
    end else if (cmd.load_start) begin
      bucket <= rem[BC_W-1:0];
      dvd    <= {rem[BC_W-1:0], 28'd0};
      rem    <= '0;
    end else if (cmd.div_step) begin
      rem <= t2[DIV_W-1:0];
      dvd <= {dvd[29:0], 2'b00};
    end
    if (cmd.probe_init) begin
      slot <= SW'(rem);
      cnt  <= '0;
    end else if (cmd.probe_next) begin
      cnt <= cnt + 1'b1;
      if (32'(slot) + 1 == 32'(ns_eff)) begin
        slot <= '0;
      end else begin
        slot <= slot + 1'b1;
      end
    end
  end

  // clearing pass address
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr <= '0;
    end else if (cmd.clear_step) begin
      clr_addr <= clr_addr + 1'b1;
    end
  end

  // table ram, word is {valid, key, value}
  assign probe_addr = AW'(32'(bucket) * MAX_SLOTS + 32'(slot));
  assign ram_we     = cmd.clear_step | cmd.wr_insert | cmd.wr_delete;
  assign ram_addr   = cmd.clear_step ? clr_addr : probe_addr;

  always_comb begin
    if (cmd.wr_insert) begin
      ram_wdata = {1'b1, key_reg, val_reg};
    end else if (cmd.wr_delete) begin
      ram_wdata = {1'b0, ram_rdata[WORD_W-2:0]};
    end else begin
      ram_wdata = '0;
    end
  end

  tlht_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .re   (cmd.ram_rd),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
    if (cmd.res_load) begin
      status      <= cmd.res_status;
      found_value <= cmd.res_value ? ram_rdata[VAL_W-1:0] : '0;
    end
  end

  // status back to the controller
  assign stat.slot_empty = !ram_rdata[WORD_W-1];
  assign stat.slot_match = ram_rdata[WORD_W-1] && (ram_rdata[WORD_W-2:VAL_W] == key_reg);
  assign stat.last_slot  = (cnt == ns_eff - 1'b1);
  assign stat.clear_last = (clr_addr == AW'(DEPTH - 1));
  assign stat.out_full   = out_valid & out_stall;

endmodule

// ----- rtl/tlht_ctrl.sv -----
// controller state machine of the two-level hash table
`timescale 1ns / 1ps
module tlht_ctrl import tlht_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] action,
  output cmd_t       cmd,
  input  stat_t      stat
);

  typedef enum logic [6:0] {
    S_CLEAR  = 7'b0000001,
    S_IDLE   = 7'b0000010,
    S_DIV_B  = 7'b0000100,
    S_DIV_S  = 7'b0001000,
    S_RD     = 7'b0010000,
    S_CHK    = 7'b0100000,
    S_FINISH = 7'b1000000
  } state_t;

  state_t              state, state_next;
  action_t             act, act_next;
  status_t             pend_status, pend_status_next;
  logic                pend_value, pend_value_next;
  logic [STEP_W-1:0]   step, step_next;

  assign in_stall = (state != S_IDLE);

  // state and item control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLEAR;
      act         <= ACT_NONE;
      pend_status <= ST_OK;
      pend_value  <= 1'b0;
      step        <= '0;
    end else begin
      state       <= state_next;
      act         <= act_next;
      pend_status <= pend_status_next;
      pend_value  <= pend_value_next;
      step        <= step_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next       = state;
    act_next         = act;
    pend_status_next = pend_status;
    pend_value_next  = pend_value;
    step_next        = step;
    cmd              = '0;
    cmd.res_status   = pend_status;
    cmd.res_value    = pend_value;
    unique case (state)
      S_CLEAR: begin
        cmd.clear_step = 1'b1;
        if (stat.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load_item    = 1'b1;
          act_next         = action_t'(action);
          pend_status_next = ST_OK;
          pend_value_next  = 1'b0;
          step_next        = '0;
          state_next       = (action_t'(action) == ACT_NONE) ? S_FINISH : S_DIV_B;
        end
      end
      S_DIV_B: begin
        cmd.div_step = 1'b1;
        step_next    = step + 1'b1;
        if (step == KEY_STEPS_LAST) begin
          step_next  = '0;
          state_next = S_DIV_S;
        end
      end
      // load bucket, two remainder steps, then take the start slot
      S_DIV_S: begin
        step_next = step + 1'b1;
        if (step == '0) begin
          cmd.load_start = 1'b1;
        end else if (step == START_STEPS_LAST + STEP_W'(2)) begin
          cmd.probe_init = 1'b1;
          state_next     = S_RD;
        end else begin
          cmd.div_step      = 1'b1;
          cmd.div_sel_slots = 1'b1;
        end
      end
      S_RD: begin
        cmd.ram_rd = 1'b1;
        state_next = S_CHK;
      end
      S_CHK: begin
        state_next = S_FINISH;
        if (act == ACT_INSERT) begin
          if (stat.slot_empty) begin
            cmd.wr_insert    = 1'b1;
            pend_status_next = ST_OK;
          end else if (stat.last_slot) begin
            pend_status_next = ST_NO_ROOM;
          end else begin
            cmd.probe_next = 1'b1;
            state_next     = S_RD;
          end
        end else begin
          if (stat.slot_match) begin
            cmd.wr_delete    = (act == ACT_DELETE);
            pend_value_next  = (act == ACT_FIND);
            pend_status_next = ST_OK;
          end else if (stat.last_slot) begin
            pend_status_next = ST_NOT_FOUND;
          end else begin
            cmd.probe_next = 1'b1;
            state_next     = S_RD;
          end
        end
      end
      S_FINISH: begin
        if (!stat.out_full) begin
          cmd.res_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/two_level_hash_table.sv -----
// top level of the two-level hash table with linear probing
//
//  channel | signals                          | direction
//  in      | in_valid, in_stall, action/key/value | into block
//  out     | out_valid, out_stall, status/found_value | out of block
//  cfg     | cfg_we, cfg_index, cfg_data      | into block
//
// after reset a clearing pass writes every table word, MAX_BUCKETS*MAX_SLOTS
// words (128 by default), with in_stall high; config writes are taken meanwhile.
// an item is accepted, its key is reduced to a bucket by the radix-4 remainder
// unit and the bucket to a start slot, then each probed slot (1 to slots in use)
// is read from the one-port ram and checked; action code 3 goes to the result.
// in_stall is high from acceptance until the result is loaded; a stalled result
// waits in the output register while the next item is accepted and processed.
`timescale 1ns / 1ps
module two_level_hash_table import tlht_pkg::*; #(
  parameter int MAX_BUCKETS = DEF_MAX_BUCKETS,
  parameter int MAX_SLOTS   = DEF_MAX_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        action,
  input  logic [KEY_W-1:0]  key,
  input  logic [VAL_W-1:0]  value,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        status,
  output logic [VAL_W-1:0]  found_value,
  input  logic              cfg_we,
  input  logic              cfg_index,
  input  logic [CFG_W-1:0]  cfg_data
);

  cmd_t  cmd;
  stat_t stat;

  // sequencing
  tlht_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .action  (action),
    .cmd     (cmd),
    .stat    (stat)
  );

  // storage and arithmetic
  tlht_datapath #(
    .MAX_BUCKETS(MAX_BUCKETS),
    .MAX_SLOTS  (MAX_SLOTS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .key        (key),
    .value      (value),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .status     (status),
    .found_value(found_value),
    .cmd        (cmd),
    .stat       (stat)
  );

endmodule

// ----- rtl/tlht_checker.sv -----
// port-level checker of the two-level hash table and its bind
`timescale 1ns / 1ps
`include "assert_macros.svh"
module tlht_checker import tlht_pkg::*; (
  input logic              clk,
  input logic              rst,
  input logic              in_valid,
  input logic              in_stall,
  input logic              out_valid,
  input logic              out_stall,
  input logic [1:0]        status,
  input logic [VAL_W-1:0]  found_value
);

  // an accepted transaction keeps the input side busy next cycle
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, in_valid && !in_stall, in_stall)
  // the unused status code never appears
  `ASSERT_SAME(a_status_legal, clk, rst, out_valid, status != ST_UNUSED)
  // a result other than ok carries a zero value
  `ASSERT_SAME(a_value_zero, clk, rst, out_valid && status != ST_OK, found_value == '0)
  // a stalled result holds
  `ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall,
               out_valid && $stable(status) && $stable(found_value))

endmodule

bind two_level_hash_table tlht_checker u_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_valid),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .status     (status),
  .found_value(found_value)
);

// ----- tb/tb.sv -----
// self-checking testbench of the two-level hash table
`timescale 1ns / 1ps
module tb;
  import tlht_pkg::*;

  localparam int NB = DEF_MAX_BUCKETS;
  localparam int NS = DEF_MAX_SLOTS;
  localparam int DEPTH = NB * NS;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [1:0]       act;
    logic [KEY_W-1:0] k;
    logic [VAL_W-1:0] v;
  } op_t;

  typedef struct packed {
    logic [1:0]       st;
    logic [VAL_W-1:0] fv;
  } reply_t;

  logic clk, rst;
  logic in_valid, in_stall, out_valid, out_stall;
  logic [1:0] action, status;
  logic [KEY_W-1:0] key;
  logic [VAL_W-1:0] value, found_value;
  logic cfg_we, cfg_index;
  logic [CFG_W-1:0] cfg_data;

  two_level_hash_table uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .key(key), .value(value), .out_valid(out_valid),
    .out_stall(out_stall), .status(status), .found_value(found_value),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  // shadow copy of the table
  logic             tbl_valid [DEPTH];
  logic [KEY_W-1:0] tbl_key   [DEPTH];
  logic [VAL_W-1:0] tbl_val   [DEPTH];
  logic [3:0]       bucket_reg;
  logic [4:0]       slots_reg;

  op_t    pending_ops[$];
  reply_t expected_replies[$];
  int     errors;
  int     cycles;
  int     send_idle_pct, recv_idle_pct;
  int     key_pool[$];

  // table lookup and update for one operation
  function automatic reply_t hash_table_apply(op_t o);
    reply_t r;
    int nb, ns, bkt, s, idx, n;
    bit hit;
    nb = (bucket_reg == 0) ? 1 : (bucket_reg > NB ? NB : bucket_reg);
    ns = (slots_reg == 0) ? 1 : (slots_reg > NS ? NS : slots_reg);
    bkt = o.k % nb;
    s = bkt % ns;
    r.st = ST_OK;
    r.fv = '0;
    hit = 0;
    idx = 0;
    if (o.act == ACT_INSERT) begin
      r.st = ST_NO_ROOM;
      for (n = 0; n < ns; n++) begin
        idx = (bkt * NS + s) % DEPTH;
        if (!tbl_valid[idx]) begin
          tbl_valid[idx] = 1;
          tbl_key[idx] = o.k;
          tbl_val[idx] = o.v;
          r.st = ST_OK;
          break;
        end
        s = (s + 1) % ns;
      end
    end else if (o.act == ACT_FIND || o.act == ACT_DELETE) begin
      for (n = 0; n < ns; n++) begin
        idx = (bkt * NS + s) % DEPTH;
        if (tbl_valid[idx] && tbl_key[idx] == o.k) begin
          hit = 1;
          break;
        end
        s = (s + 1) % ns;
      end
      if (!hit) r.st = ST_NOT_FOUND;
      else if (o.act == ACT_FIND) r.fv = tbl_val[idx];
      else tbl_valid[idx] = 0;
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h", what, got, want);
    errors++;
  endtask

  // clock
  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // driver: present queued transactions
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 0;
    end else if (!in_valid || !in_stall) begin
      if (in_valid && !in_stall) expected_replies.push_back(hash_table_apply(
        '{act: action, k: key, v: value}));
      if (pending_ops.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
        op_t o;
        o = pending_ops.pop_front();
        in_valid <= 1;
        action <= o.act;
        key <= o.k;
        value <= o.v;
      end else begin
        in_valid <= 0;
      end
    end
  end

  // monitor: compare each result transaction with the oldest expectation
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (expected_replies.size() == 0) begin
          report_mismatch("unexpected result", {30'd0, status}, 0);
        end else begin
          reply_t w;
          w = expected_replies.pop_front();
          if (status !== w.st) report_mismatch("status", {30'd0, status}, {30'd0, w.st});
          if (found_value !== w.fv) report_mismatch("found_value", found_value, w.fv);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  // timeout
  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  function automatic op_t rand_op();
    op_t o;
    int r;
    r = $urandom_range(99);
    o.act = (r < 45) ? ACT_INSERT : (r < 75) ? ACT_FIND : (r < 97) ? ACT_DELETE : ACT_NONE;
    if (key_pool.size() > 0 && $urandom_range(99) < 70)
      o.k = KEY_W'(key_pool[$urandom_range(key_pool.size() - 1)]);
    else
      o.k = KEY_W'($urandom);
    o.v = $urandom;
    if (o.act == ACT_INSERT && key_pool.size() < 40) key_pool.push_back(int'(o.k));
    return o;
  endfunction

  task automatic wait_drained();
    while (pending_ops.size() > 0 || in_valid || expected_replies.size() > 0)
      @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [CFG_W-1:0] d);
    @(posedge clk);
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= d;
    @(posedge clk);
    cfg_we <= 0;
    if (idx == CFG_BUCKET_COUNT) bucket_reg = d[3:0];
    else slots_reg = d[4:0];
  endtask

  task automatic run_phase(input int n, input logic [3:0] bc, input logic [4:0] sc);
    wait_drained();
    write_reg(CFG_BUCKET_COUNT, {1'b0, bc});
    write_reg(CFG_SLOTS_IN_USE, sc);
    for (int i = 0; i < n; i++) pending_ops.push_back(rand_op());
  endtask

  // stimulus
  initial begin
    errors = 0;
    cycles = 0;
    rst = 1;
    in_valid = 0;
    out_stall = 0;
    action = ACT_NONE;
    key = '0;
    value = '0;
    cfg_we = 0;
    cfg_index = CFG_BUCKET_COUNT;
    cfg_data = '0;
    bucket_reg = 4'd8;
    slots_reg = 5'd16;
    send_idle_pct = 29;
    recv_idle_pct = 64;
    for (int i = 0; i < DEPTH; i++) begin
      tbl_valid[i] = 0;
      tbl_key[i] = '0;
      tbl_val[i] = '0;
    end
    repeat (8) @(posedge clk);
    rst <= 0;

    // directed: extremes, duplicates, full bucket, unused action
    pending_ops.push_back('{ACT_INSERT, 31'h7fffffff, 32'h80000000});
    pending_ops.push_back('{ACT_INSERT, 31'd0, 32'h7fffffff});
    pending_ops.push_back('{ACT_INSERT, 31'd0, 32'hffffffff});
    pending_ops.push_back('{ACT_FIND, 31'h7fffffff, 32'h0});
    pending_ops.push_back('{ACT_FIND, 31'd0, 32'h0});
    pending_ops.push_back('{ACT_DELETE, 31'd0, 32'h0});
    pending_ops.push_back('{ACT_FIND, 31'd0, 32'h0});
    pending_ops.push_back('{ACT_FIND, 31'd12345, 32'h0});
    pending_ops.push_back('{ACT_DELETE, 31'd12345, 32'h0});
    pending_ops.push_back('{ACT_NONE, 31'h7fffffff, 32'hffffffff});
    pending_ops.push_back('{ACT_DELETE, 31'h7fffffff, 32'h0});
    // fill one bucket at two slots, then overflow
    run_phase(0, 4'd2, 5'd2);
    for (int i = 0; i < 3; i++) pending_ops.push_back('{ACT_INSERT, 31'(4 + 2 * i), 32'(i)});
    pending_ops.push_back('{ACT_FIND, 31'd6, 32'h0});
    // zero and oversized register values, stored entries beyond the count
    run_phase(0, 4'd0, 5'd0);
    pending_ops.push_back('{ACT_INSERT, 31'd9, 32'h55aa55aa});
    pending_ops.push_back('{ACT_INSERT, 31'd9, 32'h1});
    run_phase(0, 4'd15, 5'd31);
    pending_ops.push_back('{ACT_FIND, 31'd6, 32'h0});
    pending_ops.push_back('{ACT_FIND, 31'd8, 32'h0});

    // random phases over several settings
    run_phase(120, 4'd8, 5'd16);
    run_phase(100, 4'd1, 5'd1);
    send_idle_pct = 64;
    recv_idle_pct = 29;
    run_phase(130, 4'd3, 5'd4);
    run_phase(130, 4'd8, 5'd3);
    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_phase(130, 4'd5, 5'd16);
    run_phase(130, 4'd7, 5'd9);

    wait_drained();
    if (errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/tlht_pkg.sv
rtl/tlht_ram.sv
rtl/tlht_datapath.sv
rtl/tlht_ctrl.sv
rtl/two_level_hash_table.sv
rtl/tlht_checker.sv
tb/tb.sv
